FILE: sv/ocs_pkg.sv
// shared types and constants of the osculating circle block
`default_nettype none
package ocs_pkg;

  localparam int DATA_W        = 32;
  localparam int STEP_W        = 31;
  localparam int FRAC_BITS_DEF = 16;
  // 1 + p^2 in Q(2F)
  localparam int S_W           = 63;
  localparam int ROOT_W        = 32;
  localparam int QB_PQ         = 33;
  localparam int QB_FIN        = 41;
  localparam int PROD_W        = 95;

  localparam logic [STEP_W-1:0]   STEP_RESET    = 31'd655;
  localparam logic [2*STEP_W-1:0] STEP_SQ_RESET = 62'(STEP_RESET) * 62'(STEP_RESET);

  localparam logic [QB_PQ:0]  LIM_POS_PQ = 34'h0_7fff_ffff;
  localparam logic [QB_PQ:0]  LIM_NEG_PQ = 34'h0_8000_0000;
  localparam logic [QB_FIN:0] LIM_RAD    = 42'h000_7fff_ffff;
  localparam logic [QB_FIN:0] LIM_OFF    = 42'h100_0000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_position;
    logic signed [DATA_W-1:0] sample_left;
    logic signed [DATA_W-1:0] sample_mid;
    logic signed [DATA_W-1:0] sample_right;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] first_derivative;
    logic signed [DATA_W-1:0] second_derivative;
    logic [DATA_W-2:0]        radius;
    logic signed [DATA_W-1:0] center_x;
    logic signed [DATA_W-1:0] center_y;
    logic                     flat_flag;
    logic                     saturate_flag;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] m;
    logic              dn_neg;
  } pq_side_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] pm;
    logic [DATA_W-1:0] qm;
    logic              sat;
  } core_t;

  typedef struct packed {
    core_t          core;
    logic [S_W-1:0] s;
  } root_side_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] q;
  } n_side_t;

endpackage
`default_nettype wire

FILE: sv/ocs_div.sv
// pipelined restoring divider, one quotient bit per stage, rounded half away from zero
`default_nettype none
module ocs_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QB = 33,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QB:0]        out_quo,
  output logic               out_ovf,
  output logic [SW-1:0]      out_side
);

  logic          v_r    [QB+1];
  logic          ovf_r  [QB+1];
  logic [DW-1:0] rem_r  [QB+1];
  logic [QB-1:0] qn_r   [QB+1];
  logic [DW-1:0] den_r  [QB+1];
  logic [SW-1:0] side_r [QB+1];

  logic [DW-1:0] rem_nxt [QB+1];
  logic [QB-1:0] qn_nxt  [QB+1];
  logic          ovf_nxt;
  logic [QB:0]   quo_nxt;

  logic          out_v_r;
  logic [QB:0]   out_quo_r;
  logic          out_ovf_r;
  logic [SW-1:0] out_side_r;

  always_comb begin
    logic [DW:0] rem2;
    logic [DW:0] diff;
    logic        ge;
    logic        up;
    rem2 = '0;
    diff = '0;
    ge   = 1'b0;
    // quotient beyond QB bits means the caller clamps anyway
    ovf_nxt    = {{DW{1'b0}}, in_num[NW-1:QB]} >= {{(NW-QB){1'b0}}, in_den};
    rem_nxt[0] = DW'({{DW{1'b0}}, in_num[NW-1:QB]});
    qn_nxt[0]  = in_num[QB-1:0];
    for (int k = 1; k <= QB; k++) begin
      rem2       = {rem_r[k-1], qn_r[k-1][QB-1]};
      ge         = rem2 >= {1'b0, den_r[k-1]};
      diff       = rem2 - {1'b0, den_r[k-1]};
      rem_nxt[k] = ge ? diff[DW-1:0] : rem2[DW-1:0];
      qn_nxt[k]  = {qn_r[k-1][QB-2:0], ge};
    end
    up      = {rem_r[QB], 1'b0} >= {1'b0, den_r[QB]};
    quo_nxt = {1'b0, qn_r[QB]} + (QB+1)'(up);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) v_r[k] <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= QB; k++) v_r[k] <= v_r[k-1];
      out_v_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt[0];
      qn_r[0]   <= qn_nxt[0];
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      ovf_r[0]  <= ovf_nxt;
      for (int k = 1; k <= QB; k++) begin
        rem_r[k]  <= rem_nxt[k];
        qn_r[k]   <= qn_nxt[k];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
      end
      out_quo_r  <= quo_nxt;
      out_ovf_r  <= ovf_r[QB];
      out_side_r <= side_r[QB];
    end
  end

  assign out_valid = out_v_r;
  assign out_quo   = out_quo_r;
  assign out_ovf   = out_ovf_r;
  assign out_side  = out_side_r;

endmodule
`default_nettype wire

FILE: sv/ocs_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module ocs_sqrt #(
  parameter int SW = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [ocs_pkg::S_W-1:0]   in_val,
  input  wire logic [SW-1:0]             in_side,
  output logic                           out_valid,
  output logic [ocs_pkg::ROOT_W-1:0]     out_root,
  output logic [SW-1:0]                  out_side
);

  localparam int NS = ocs_pkg::ROOT_W;
  localparam int RW = 2 * ocs_pkg::ROOT_W;

  logic          v_r    [NS];
  logic [RW-1:0] s_r    [NS];
  logic [RW-1:0] r_r    [NS];
  logic [SW-1:0] side_r [NS];

  logic [RW-1:0] src_s [NS];
  logic [RW-1:0] src_r [NS];
  logic [RW-1:0] s_nxt [NS];
  logic [RW-1:0] r_nxt [NS];

  always_comb begin
    logic [RW-1:0] b;
    logic [RW-1:0] rb;
    logic          ge;
    b  = '0;
    rb = '0;
    ge = 1'b0;
    src_s[0] = RW'(in_val);
    src_r[0] = '0;
    for (int k = 1; k < NS; k++) begin
      src_s[k] = s_r[k-1];
      src_r[k] = r_r[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      b        = RW'(1) << (RW - 2 - 2 * k);
      rb       = src_r[k] + b;
      ge       = src_s[k] >= rb;
      s_nxt[k] = ge ? src_s[k] - rb : src_s[k];
      r_nxt[k] = ge ? (src_r[k] >> 1) + b : src_r[k] >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 1; k < NS; k++) side_r[k] <= side_r[k-1];
      for (int k = 0; k < NS; k++) begin
        s_r[k] <= s_nxt[k];
        r_r[k] <= r_nxt[k];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = r_r[NS-1][ocs_pkg::ROOT_W-1:0];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire

FILE: sv/osculating_circle_from_samples_top.sv
// osculating circle of a sampled curve: top level
//
// input channel in_valid/in_ready/in_data carries one point per transaction:
// the abscissa and the curve samples at x-h, x and x+h, signed fixed point.
// result channel out_valid/out_ready/out_data returns one transaction per
// input: slope, second difference, radius of curvature, circle centre, flags.
// cfg_valid/cfg_ready/cfg_data writes the sample spacing h (zero acts as one);
// change it only while no transaction is in flight.
// one transaction per cycle is taken and delivered while the receiver does
// not stall. the depth is set by the bit-serial dividers (35 and 43 stages)
// and the 32-stage square root, all pipelined. reset empties the pipeline
// and loads h = 655; cfg_ready and in_ready are low during reset. when the
// receiver stalls, the output register holds its transaction and a skid
// register takes one more; then in_ready drops and the whole pipeline
// freezes until out_ready returns, so nothing is lost.
`default_nettype none
module osculating_circle_from_samples_top #(
  parameter int FRAC_BITS = ocs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ocs_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ocs_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ocs_pkg::STEP_W-1:0]  cfg_data
);

  localparam int NW_P = 32 + FRAC_BITS;
  localparam int NW_Q = 33 + 2 * FRAC_BITS;
  localparam int DW_P = 32;
  localparam int DW_Q = 2 * ocs_pkg::STEP_W;
  localparam int DW_F = 32 + FRAC_BITS;
  localparam int QP   = ocs_pkg::QB_PQ;
  localparam int QF   = ocs_pkg::QB_FIN;

  logic en;

  // step register and its square
  logic [ocs_pkg::STEP_W-1:0]   h_r, h_nxt;
  logic [2*ocs_pkg::STEP_W-1:0] h2_r, h2_nxt;

  assign cfg_ready = rst_n;
  assign h_nxt     = (cfg_data == '0) ? ocs_pkg::STEP_W'(1) : cfg_data;
  assign h2_nxt    = DW_Q'(h_nxt) * DW_Q'(h_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r  <= ocs_pkg::STEP_RESET;
      h2_r <= ocs_pkg::STEP_SQ_RESET;
    end else if (cfg_valid) begin
      h_r  <= h_nxt;
      h2_r <= h2_nxt;
    end
  end

  // stage 1: differences
  logic [32:0] dn_nxt, dn_neg_v;
  logic [33:0] d2_nxt, d2_neg_v;
  logic [31:0] dnm_nxt;
  logic [32:0] d2m_nxt;

  logic              s1_v_r;
  logic [31:0]       dnm_r;
  logic [32:0]       d2m_r;
  logic              d2_neg_r;
  ocs_pkg::pq_side_t s1_side_r;

  always_comb begin
    dn_nxt   = {in_data.sample_right[31], in_data.sample_right}
             - {in_data.sample_left[31], in_data.sample_left};
    d2_nxt   = {{2{in_data.sample_right[31]}}, in_data.sample_right}
             + {{2{in_data.sample_left[31]}}, in_data.sample_left}
             - {in_data.sample_mid[31], in_data.sample_mid, 1'b0};
    dn_neg_v = 33'd0 - dn_nxt;
    d2_neg_v = 34'd0 - d2_nxt;
    dnm_nxt  = dn_nxt[32] ? dn_neg_v[31:0] : dn_nxt[31:0];
    d2m_nxt  = d2_nxt[33] ? d2_neg_v[32:0] : d2_nxt[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r           <= in_valid;
      dnm_r            <= dnm_nxt;
      d2m_r            <= d2m_nxt;
      d2_neg_r         <= d2_nxt[33];
      s1_side_r.x      <= in_data.x_position;
      s1_side_r.m      <= in_data.sample_mid;
      s1_side_r.dn_neg <= dn_nxt[32];
    end
  end

  // slope and second difference dividers
  logic                          p_v, q_v, p_ovf, q_ovf;
  logic [QP:0]                   p_quo, q_quo;
  logic [$bits(ocs_pkg::pq_side_t)-1:0] p_side_v;
  logic                          q_side_v;

  ocs_div #(.NW(NW_P), .DW(DW_P), .QB(QP), .SW($bits(ocs_pkg::pq_side_t))) u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s1_v_r),
    .in_num   ({dnm_r, {FRAC_BITS{1'b0}}}),
    .in_den   ({h_r, 1'b0}),
    .in_side  (s1_side_r),
    .out_valid(p_v),
    .out_quo  (p_quo),
    .out_ovf  (p_ovf),
    .out_side (p_side_v)
  );

  ocs_div #(.NW(NW_Q), .DW(DW_Q), .QB(QP), .SW(1)) u_div_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s1_v_r),
    .in_num   ({d2m_r, {(2*FRAC_BITS){1'b0}}}),
    .in_den   (h2_r),
    .in_side  (d2_neg_r),
    .out_valid(q_v),
    .out_quo  (q_quo),
    .out_ovf  (q_ovf),
    .out_side (q_side_v)
  );

  // stage 2: saturate p and q
  ocs_pkg::pq_side_t p_side;
  logic [QP:0]       p_lim, q_lim;
  logic              p_clip, q_clip;
  logic [31:0]       p_mag, q_mag;
  ocs_pkg::core_t    s2_nxt, s2_r;
  logic              s2_v_r;

  always_comb begin
    p_side = p_side_v;
    p_lim  = p_side.dn_neg ? ocs_pkg::LIM_NEG_PQ : ocs_pkg::LIM_POS_PQ;
    q_lim  = q_side_v ? ocs_pkg::LIM_NEG_PQ : ocs_pkg::LIM_POS_PQ;
    p_clip = p_ovf || (p_quo > p_lim);
    q_clip = q_ovf || (q_quo > q_lim);
    p_mag  = p_clip ? p_lim[31:0] : p_quo[31:0];
    q_mag  = q_clip ? q_lim[31:0] : q_quo[31:0];
    s2_nxt.x   = p_side.x;
    s2_nxt.m   = p_side.m;
    s2_nxt.p   = p_side.dn_neg ? 32'd0 - p_mag : p_mag;
    s2_nxt.q   = q_side_v ? 32'd0 - q_mag : q_mag;
    s2_nxt.pm  = p_mag;
    s2_nxt.qm  = q_mag;
    s2_nxt.sat = p_clip || q_clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= p_v && q_v;
      s2_r   <= s2_nxt;
    end
  end

  // stage 3: s = 1 + p^2
  logic [63:0]         pm_sq;
  ocs_pkg::root_side_t s3_r;
  logic                s3_v_r;

  assign pm_sq = 64'(s2_r.pm) * 64'(s2_r.pm);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r    <= s2_v_r;
      s3_r.core <= s2_r;
      s3_r.s    <= ocs_pkg::S_W'(pm_sq) + (ocs_pkg::S_W'(1) << (2 * FRAC_BITS));
    end
  end

  // square root of s
  logic                                    t_v;
  logic [ocs_pkg::ROOT_W-1:0]              t_root;
  logic [$bits(ocs_pkg::root_side_t)-1:0]  t_side_v;
  ocs_pkg::root_side_t                     t_side;

  ocs_sqrt #(.SW($bits(ocs_pkg::root_side_t))) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s3_v_r),
    .in_val   (s3_r.s),
    .in_side  (s3_r),
    .out_valid(t_v),
    .out_root (t_root),
    .out_side (t_side_v)
  );

  assign t_side = t_side_v;

  // stage 4: partial products of s*t and pm*s
  logic                s4_v_r;
  ocs_pkg::root_side_t s4_r;
  logic [62:0]         st_hi_r, ps_hi_r;
  logic [63:0]         st_lo_r, ps_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r  <= t_v;
      s4_r    <= t_side;
      st_hi_r <= 63'(t_side.s[62:32]) * 63'(t_root);
      st_lo_r <= 64'(t_side.s[31:0]) * 64'(t_root);
      ps_hi_r <= 63'(t_side.s[62:32]) * 63'(t_side.core.pm);
      ps_lo_r <= 64'(t_side.s[31:0]) * 64'(t_side.core.pm);
    end
  end

  // stage 5: full products
  logic                           s5_v_r;
  ocs_pkg::root_side_t            s5_r;
  logic [ocs_pkg::PROD_W-1:0]     st_r, ps_r;
  ocs_pkg::n_side_t               n_in_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
      s5_r   <= s4_r;
      st_r   <= (ocs_pkg::PROD_W'(st_hi_r) << 32) + ocs_pkg::PROD_W'(st_lo_r);
      ps_r   <= (ocs_pkg::PROD_W'(ps_hi_r) << 32) + ocs_pkg::PROD_W'(ps_lo_r);
    end
  end

  assign n_in_side.x = s5_r.core.x;
  assign n_in_side.m = s5_r.core.m;
  assign n_in_side.q = s5_r.core.q;

  // radius, normal offset and abscissa shift dividers
  logic                               r_v, n_v, m_v, r_ovf, n_ovf, m_ovf;
  logic [QF:0]                        r_quo, n_quo, m_quo;
  logic                               r_side_v;
  logic [$bits(ocs_pkg::n_side_t)-1:0] n_side_v;
  logic [31:0]                        m_side_v;

  ocs_div #(.NW(ocs_pkg::PROD_W), .DW(DW_F), .QB(QF), .SW(1)) u_div_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s5_v_r),
    .in_num   (st_r),
    .in_den   ({s5_r.core.qm, {FRAC_BITS{1'b0}}}),
    .in_side  (s5_r.core.sat),
    .out_valid(r_v),
    .out_quo  (r_quo),
    .out_ovf  (r_ovf),
    .out_side (r_side_v)
  );

  ocs_div #(.NW(ocs_pkg::S_W), .DW(32), .QB(QF), .SW($bits(ocs_pkg::n_side_t))) u_div_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s5_v_r),
    .in_num   (s5_r.s),
    .in_den   (s5_r.core.qm),
    .in_side  (n_in_side),
    .out_valid(n_v),
    .out_quo  (n_quo),
    .out_ovf  (n_ovf),
    .out_side (n_side_v)
  );

  ocs_div #(.NW(ocs_pkg::PROD_W), .DW(DW_F), .QB(QF), .SW(32)) u_div_m (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s5_v_r),
    .in_num   (ps_r),
    .in_den   ({s5_r.core.qm, {FRAC_BITS{1'b0}}}),
    .in_side  (s5_r.core.p),
    .out_valid(m_v),
    .out_quo  (m_quo),
    .out_ovf  (m_ovf),
    .out_side (m_side_v)
  );

  // stage 6: centre, flat case, saturation
  ocs_pkg::n_side_t n_side;
  logic             qneg, pneg, flat, r_clip, cy_hi, cy_lo, cx_hi, cx_lo;
  logic [40:0]      nm, mm;
  logic [42:0]      nv, mv, cy_w, cx_w;
  logic [30:0]      rad;
  logic [31:0]      cy, cx, cx_flat;
  ocs_pkg::out_t    s6_nxt, s6_r;
  logic             s6_v_r;

  always_comb begin
    n_side = n_side_v;
    qneg   = n_side.q[31];
    pneg   = m_side_v[31];
    flat   = (n_side.q == '0);
    r_clip = r_ovf || (r_quo > ocs_pkg::LIM_RAD);
    rad    = r_clip ? ocs_pkg::LIM_RAD[30:0] : r_quo[30:0];
    nm     = (n_ovf || (n_quo > ocs_pkg::LIM_OFF)) ? ocs_pkg::LIM_OFF[40:0] : n_quo[40:0];
    mm     = (m_ovf || (m_quo > ocs_pkg::LIM_OFF)) ? ocs_pkg::LIM_OFF[40:0] : m_quo[40:0];
    nv     = qneg ? 43'd0 - {2'b00, nm} : {2'b00, nm};
    mv     = (pneg ^ qneg) ? 43'd0 - {2'b00, mm} : {2'b00, mm};
    cy_w   = {{11{n_side.m[31]}}, n_side.m} + nv;
    cx_w   = {{11{n_side.x[31]}}, n_side.x} - mv;
    cy_hi  = $signed(cy_w) > 43'sd2147483647;
    cy_lo  = $signed(cy_w) < -43'sd2147483648;
    cx_hi  = $signed(cx_w) > 43'sd2147483647;
    cx_lo  = $signed(cx_w) < -43'sd2147483648;
    cy     = cy_hi ? 32'h7fff_ffff : (cy_lo ? 32'h8000_0000 : cy_w[31:0]);
    cx     = cx_hi ? 32'h7fff_ffff : (cx_lo ? 32'h8000_0000 : cx_w[31:0]);
    // limit as q goes to zero from above
    cx_flat = (m_side_v == '0) ? n_side.x : (pneg ? 32'h7fff_ffff : 32'h8000_0000);

    s6_nxt.first_derivative  = m_side_v;
    s6_nxt.second_derivative = n_side.q;
    s6_nxt.flat_flag         = flat;
    if (flat) begin
      s6_nxt.radius        = ocs_pkg::LIM_RAD[30:0];
      s6_nxt.center_x      = cx_flat;
      s6_nxt.center_y      = 32'h7fff_ffff;
      s6_nxt.saturate_flag = r_side_v;
    end else begin
      s6_nxt.radius        = rad;
      s6_nxt.center_x      = cx;
      s6_nxt.center_y      = cy;
      s6_nxt.saturate_flag = r_side_v || r_clip || cy_hi || cy_lo || cx_hi || cx_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= r_v && n_v && m_v;
      s6_r   <= s6_nxt;
    end
  end

  // output register with one skid entry
  logic          out_v_r, skid_v_r;
  ocs_pkg::out_t out_r, skid_r;

  assign en       = !skid_v_r;
  assign in_ready = rst_n && !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_r   <= s6_r;
        out_v_r <= s6_v_r;
      end
    end else if (!skid_v_r && s6_v_r) begin
      skid_r   <= s6_r;
      skid_v_r <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: sv/ocs_checker.sv
// port-level checks for the osculating circle block, bound to the top level
`default_nettype none
module ocs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire ocs_pkg::out_t               out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // flat flag matches a zero second difference, with saturated radius and centre height
  a_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.flat_flag == (out_data.second_derivative == '0)) &&
                  (!out_data.flat_flag ||
                   (out_data.radius == 31'h7fff_ffff && out_data.center_y == 32'h7fff_ffff)))
    else $error("flat result inconsistent");

  // input side only stalls after the result side stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output stall");

endmodule

bind osculating_circle_from_samples_top ocs_checker u_ocs_checker (.*);
`default_nettype wire

FILE: bench/osculating_circle_from_samples_top_test.sv
// testbench of the osculating circle block: predicted results checked per transaction
`timescale 1ns / 1ps
module osculating_circle_from_samples_top_test;

  localparam int FB = 16;
  localparam int LATENCY = 116;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ocs_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ocs_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ocs_pkg::STEP_W-1:0] cfg_data = '0;

  osculating_circle_from_samples_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  ocs_pkg::in_t pending_points[$];
  ocs_pkg::out_t circle_expected[$];
  logic [ocs_pkg::STEP_W-1:0] spacing = ocs_pkg::STEP_RESET;
  idle_mode_t idle_mode = IDLE_NONE;
  bit hold_off = 1'b0;
  bit hold_go = 1'b0;
  bit in_took = 1'b0;
  int mismatches = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // rounded magnitude division, ties away from zero
  function automatic logic [127:0] div_round(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q, r;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return q;
  endfunction

  function automatic logic [63:0] clip(input logic [127:0] v, input logic [63:0] lim,
                                       inout bit clipped);
    if (v > {64'd0, lim}) begin
      clipped = 1'b1;
      return lim;
    end
    return v[63:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] s);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ({64'd0, r | (64'd1 << b)} * {64'd0, r | (64'd1 << b)} <= {64'd0, s}) r |= 64'd1 << b;
    return r;
  endfunction

  function automatic longint sat32(input longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin clipped = 1'b1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin clipped = 1'b1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic ocs_pkg::out_t osculate(input ocs_pkg::in_t pt,
                                             input logic [ocs_pkg::STEP_W-1:0] hstep);
    ocs_pkg::out_t res;
    longint x, l, m, r, dn, d2, p, q, cx, cy, nv, mv;
    logic [63:0] h, pm, qm, s, t, rad, nm, mm;
    bit sat, dummy;
    x = pt.x_position; l = pt.sample_left; m = pt.sample_mid; r = pt.sample_right;
    h = (hstep == 0) ? 64'd1 : 64'(hstep);
    sat = 0; dummy = 0;
    dn = r - l; d2 = r - 2 * m + l;
    pm = clip(div_round(128'(dn < 0 ? -dn : dn) << FB, 128'(2 * h)),
              dn < 0 ? 64'h8000_0000 : 64'h7fff_ffff, sat);
    p = dn < 0 ? -longint'(pm) : longint'(pm);
    qm = clip(div_round(128'(d2 < 0 ? -d2 : d2) << (2 * FB), 128'(h) * 128'(h)),
              d2 < 0 ? 64'h8000_0000 : 64'h7fff_ffff, sat);
    q = d2 < 0 ? -longint'(qm) : longint'(qm);
    if (q == 0) begin
      res.flat_flag = 1'b1;
      rad = 64'h7fff_ffff;
      cy = 64'sd2147483647;
      cx = (p == 0) ? x : (p > 0 ? -64'sd2147483648 : 64'sd2147483647);
    end else begin
      res.flat_flag = 1'b0;
      s = (64'd1 << (2 * FB)) + pm * pm;
      t = root_floor(s);
      rad = clip(div_round(128'(s) * 128'(t), 128'(qm) << FB), 64'h7fff_ffff, sat);
      nm = clip(div_round(128'(s), 128'(qm)), 64'd1 << 40, dummy);
      nv = q < 0 ? -longint'(nm) : longint'(nm);
      cy = sat32(m + nv, sat);
      mm = clip(div_round(128'(pm) * 128'(s), 128'(qm) << FB), 64'd1 << 40, dummy);
      mv = ((p < 0) != (q < 0)) ? -longint'(mm) : longint'(mm);
      cx = sat32(x - mv, sat);
    end
    res.first_derivative = p[31:0];
    res.second_derivative = q[31:0];
    res.radius = rad[30:0];
    res.center_x = cx[31:0];
    res.center_y = cy[31:0];
    res.saturate_flag = sat;
    return res;
  endfunction

  function automatic bit idle_roll(input bit sender);
    case (idle_mode)
      IDLE_SEND: return sender && ($urandom_range(99) < 79);
      IDLE_RECV: return !sender && ($urandom_range(99) < 79);
      IDLE_BOTH: return $urandom_range(99) < 33;
      default:   return 1'b0;
    endcase
  endfunction

  // acceptance is seen at the rising edge, where the handshake counts
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
  end

  // driver: predicts at acceptance so config changes between phases are honored
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        circle_expected.push_back(osculate(in_data, spacing));
        void'(pending_points.pop_front());
      end
      if (!in_valid || in_took) begin
        if (pending_points.size() > 0 && !idle_roll(1'b1)) begin
          in_valid <= 1'b1;
          in_data <= pending_points[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !hold_off && !idle_roll(1'b0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (circle_expected.size() == 0) begin
        $display("mismatch: unexpected transaction");
        mismatches++;
      end else begin
        ocs_pkg::out_t want;
        want = circle_expected.pop_front();
        if (out_data.first_derivative !== want.first_derivative)
          report("first_derivative", out_data.first_derivative, want.first_derivative);
        if (out_data.second_derivative !== want.second_derivative)
          report("second_derivative", out_data.second_derivative, want.second_derivative);
        if (out_data.radius !== want.radius)
          report("radius", 32'(out_data.radius), 32'(want.radius));
        if (out_data.center_x !== want.center_x)
          report("center_x", out_data.center_x, want.center_x);
        if (out_data.center_y !== want.center_y)
          report("center_y", out_data.center_y, want.center_y);
        if (out_data.flat_flag !== want.flat_flag)
          report("flat_flag", 32'(out_data.flat_flag), 32'(want.flat_flag));
        if (out_data.saturate_flag !== want.saturate_flag)
          report("saturate_flag", 32'(out_data.saturate_flag), 32'(want.saturate_flag));
      end
    end
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  function automatic logic [31:0] rand_edge();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // mostly smooth samples around a random point, some from extreme, zero or random values
  function automatic ocs_pkg::in_t rand_point();
    ocs_pkg::in_t pt;
    int spread;
    pt.x_position = $urandom();
    if ($urandom_range(3) == 0) begin
      pt.sample_left = rand_edge(); pt.sample_mid = rand_edge(); pt.sample_right = rand_edge();
    end else begin
      spread = 1 << $urandom_range(24);
      pt.sample_mid = $signed($urandom()) >>> $urandom_range(12);
      pt.sample_left = pt.sample_mid + $signed($urandom_range(2 * spread)) - spread;
      pt.sample_right = pt.sample_mid + $signed($urandom_range(2 * spread)) - spread;
      if ($urandom_range(7) == 0) pt.sample_right = 2 * pt.sample_mid - pt.sample_left;
    end
    return pt;
  endfunction

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || circle_expected.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [ocs_pkg::STEP_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    spacing = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push(input logic [31:0] x, input logic [31:0] l, input logic [31:0] m,
                      input logic [31:0] r);
    ocs_pkg::in_t pt;
    pt.x_position = x; pt.sample_left = l; pt.sample_mid = m; pt.sample_right = r;
    pending_points.push_back(pt);
  endtask

  logic [ocs_pkg::STEP_W-1:0] spacings[6] =
    '{31'd655, 31'd1, 31'h7fff_ffff, 31'd0, 31'd65536, 31'd40};

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: extremes, flat, tiny curvature, saturation
    push(32'h0, 32'h0, 32'h0, 32'h0);
    push(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    push(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    push(32'h1234_5678, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
    push(32'h1234_5678, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
    push(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000);
    push(32'hffff_0000, 32'hffff_0000, 32'h0, 32'hffff_0000);
    push(32'h0, 32'h0, 32'h0, 32'h1);
    push(32'h0, 32'h1, 32'h0, 32'h0);
    push(32'h0, 32'h0, 32'h1, 32'h0);
    push(32'h7fff_ffff, 32'h0, 32'h0100_0000, 32'h0200_0000);
    push(32'h8000_0000, 32'h0200_0000, 32'h0100_0000, 32'h0);
    push(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_spacing(spacings[ph]);
      idle_mode = idle_mode_t'(ph % 4);
      for (int i = 0; i < 260; i++) pending_points.push_back(rand_point());
      // sender runs without gaps here, so the hold-off fills the pipeline
      if (ph == 0) hold_go = 1'b1;
      drain();
    end
    write_spacing(ocs_pkg::STEP_W'($urandom_range(2147483647, 1)));
    for (int i = 0; i < 100; i++) pending_points.push_back(rand_point());
    drain();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #(20ns * 400000);
    $display("simulation failed");
    $finish;
  end

endmodule
